// ===== rtl/kgsq_pkg.sv =====
`timescale 1ns / 1ps

package kgsq_pkg;

  localparam int SEQ_W  = 16;
  localparam int HDL_W  = 16;
  localparam int LEN_W  = 11;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENABLED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_PRESENT = 1'd1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_GATED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_DISABLED = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_ZERO_LEN = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_FLUSH_INSERT,
    OP_REMOVE
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic             key;
    logic [LEN_W-1:0] len;
    logic [HDL_W-1:0] handle;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  typedef struct packed {
    logic    capture;
    logic    compare;
    logic    load;
    logic    clear;
    op_t     op;
    status_t status;
    logic    entry_valid;
    logic    prepared;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             len_zero;
    logic             req_key;
    logic             dup;
    logic             full;
    logic             empty;
    logic             head_key;
    logic             new_head_key;
    logic             pop_head_key;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== rtl/keyframe_gated_seq_sorted_queue_core.sv =====
`timescale 1ns / 1ps

// Sorted packet descriptor queue with keyframe gating. Requests (push, pop,
// peek) are taken one at a time and each returns exactly one result. With the
// output free a request goes through its steps in order: the transfer captures
// it, the S_CMP state runs the per-entry sequence compare across the register
// array, and the S_EXEC state commits the shift-insert or shift-remove and
// loads the output register, where the result is registered. A held output
// stalls the commit; the next request is not taken until then. Writing
// queue_enabled to 0 empties the queue at once; no clearing pass is needed
// after reset. Configuration writes are always ready.

module keyframe_gated_seq_sorted_queue_core
  import kgsq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // seq_number[15:0], payload_handle[31:16], payload_length[42:32], keyframe[43]
  input  logic [47:0]          s_tdata,
  // req_type[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_seq[15:0], out_handle[31:16], out_length[42:32], out_keyframe[43],
  // prepared[44]
  output logic [47:0]          m_tdata,
  // status[2:0], entry_valid[3]
  output logic [3:0]           m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  logic     queue_enabled;
  logic     viewer_present;
  logic     cfg_clear;
  cmd_t     cmd;
  dp_stat_t stat;
  entry_t   in_entry;
  entry_t   out_entry;
  status_t  out_status;
  logic     out_entry_valid;
  logic     out_prepared;

  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid && (cfg_index == CFG_QUEUE_ENABLED) && !cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_enabled  <= 1'b0;
      viewer_present <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_QUEUE_ENABLED:  queue_enabled  <= cfg_data;
        CFG_VIEWER_PRESENT: viewer_present <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_entry.seq    = s_tdata[15:0];
  assign in_entry.handle = s_tdata[31:16];
  assign in_entry.len    = s_tdata[42:32];
  assign in_entry.key    = s_tdata[43];

  kgsq_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .queue_enabled  (queue_enabled),
    .viewer_present (viewer_present),
    .cfg_clear      (cfg_clear),
    .stat           (stat),
    .cmd            (cmd)
  );

  kgsq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_req_type     (s_tuser),
    .in_entry        (in_entry),
    .stat            (stat),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_status      (out_status),
    .out_entry_valid (out_entry_valid),
    .out_entry       (out_entry),
    .out_prepared    (out_prepared)
  );

  assign m_tdata = {3'b000, out_prepared, out_entry.key, out_entry.len,
                    out_entry.handle, out_entry.seq};
  assign m_tuser = {out_entry_valid, out_status};

endmodule

// ===== rtl/kgsq_ctrl.sv =====
`timescale 1ns / 1ps

module kgsq_ctrl
  import kgsq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     queue_enabled,
  input  logic     viewer_present,
  input  logic     cfg_clear,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CMP;
      S_CMP:  state_next = S_EXEC;
      S_EXEC: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op_t     op;
    status_t st;
    logic    ev;
    logic    prep;
    op   = OP_NONE;
    st   = ST_OK;
    ev   = 1'b0;
    prep = 1'b0;
    unique case (stat.req_type) inside
      REQ_PUSH: begin
        if (stat.len_zero) begin
          st = ST_ZERO_LEN;
        end else if (!queue_enabled) begin
          st = ST_DISABLED;
        end else if (stat.dup) begin
          st = ST_DUP;
        end else if (viewer_present) begin
          if (stat.full) begin
            st = ST_FULL;
          end else begin
            op   = OP_INSERT;
            prep = stat.new_head_key;
          end
        end else if (stat.req_key) begin
          op   = OP_FLUSH_INSERT;
          prep = 1'b1;
        end else if (!stat.head_key) begin
          st = ST_GATED;
        end else if (stat.full) begin
          st = ST_FULL;
        end else begin
          op = OP_INSERT;
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (!queue_enabled) begin
          st = ST_DISABLED;
        end else if (stat.empty) begin
          st = ST_EMPTY;
        end else begin
          ev = 1'b1;
          if (stat.req_type == REQ_POP) begin
            op   = OP_REMOVE;
            prep = stat.pop_head_key;
          end
        end
      end
      default: begin
      end
    endcase

    in_ready        = (state == S_IDLE);
    cmd.capture     = (state == S_IDLE) && in_valid;
    cmd.compare     = (state == S_CMP);
    cmd.load        = (state == S_EXEC) && stat.out_free;
    cmd.clear       = cfg_clear;
    cmd.op          = op;
    cmd.status      = st;
    cmd.entry_valid = ev;
    cmd.prepared    = prep;
  end

endmodule

// ===== rtl/kgsq_datapath.sv =====
`timescale 1ns / 1ps

module kgsq_datapath
  import kgsq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [REQ_W-1:0] in_req_type,
  input  entry_t           in_entry,
  output dp_stat_t         stat,
  input  logic             out_ready,
  output logic             out_valid,
  output status_t          out_status,
  output logic             out_entry_valid,
  output entry_t           out_entry,
  output logic             out_prepared
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t           slot [CAPACITY];
  entry_t           prev_slot [CAPACITY];
  entry_t           next_slot [CAPACITY];
  logic [CAPACITY-1:0] prev_gt;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] gt_vec;
  logic [CAPACITY-1:0] end_vec;
  logic [CNT_W-1:0] count;
  logic [REQ_W-1:0] req_type;
  entry_t           req;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type <= in_req_type;
      req      <= in_entry;
    end
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_slot
    localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
    localparam bit IS_HEAD = (gi == 0);

    if (gi == 0) begin : g_first
      assign prev_slot[gi] = req;
      assign prev_gt[gi]   = 1'b0;
    end else begin : g_rest
      assign prev_slot[gi] = slot[gi-1];
      assign prev_gt[gi]   = gt_vec[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign next_slot[gi] = slot[gi];
    end else begin : g_inner
      assign next_slot[gi] = slot[gi+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        match_vec[gi] <= (IDX < count) && (slot[gi].seq == req.seq);
        gt_vec[gi]    <= (IDX < count) && (slot[gi].seq > req.seq);
        end_vec[gi]   <= (IDX == count);
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        case (cmd.op)
          OP_INSERT: begin
            if (prev_gt[gi]) begin
              slot[gi] <= prev_slot[gi];
            end else if (gt_vec[gi] || end_vec[gi]) begin
              slot[gi] <= req;
            end
          end
          OP_FLUSH_INSERT: if (IS_HEAD) slot[gi] <= req;
          OP_REMOVE:       slot[gi] <= next_slot[gi];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.load) begin
      case (cmd.op)
        OP_INSERT:       count <= count + CNT_W'(1);
        OP_FLUSH_INSERT: count <= CNT_W'(1);
        OP_REMOVE:       count <= count - CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status      <= cmd.status;
      out_entry_valid <= cmd.entry_valid;
      out_entry       <= cmd.entry_valid ? slot[0] : '0;
      out_prepared    <= cmd.prepared;
    end
  end

  always_comb begin
    stat.req_type     = req_type;
    stat.len_zero     = (req.len == '0);
    stat.req_key      = req.key;
    stat.dup          = |match_vec;
    stat.full         = (count == CNT_W'(CAPACITY));
    stat.empty        = (count == '0);
    stat.head_key     = (count != '0) && slot[0].key;
    stat.new_head_key = (gt_vec[0] || count == '0) ? req.key : slot[0].key;
    stat.pop_head_key = (count > CNT_W'(1)) && slot[1].key;
    stat.out_free     = !out_valid || out_ready;
  end

endmodule
